### rtl/smas_pkg.sv
`default_nettype none

package smas_pkg;

   localparam int SAMPLES_DEF     = 8;
   localparam int MAX_RETRIES_DEF = 3;

   localparam int RAW_W     = 12;
   localparam int HUM_W     = 14;
   localparam int RETRY_W   = 8;
   localparam int QUO_W     = 14;
   localparam int NUM_W     = RAW_W + QUO_W;
   localparam int STEP_W    = $clog2(QUO_W);
   localparam int CSR_IDX_W = 2;

   localparam logic [HUM_W-1:0] HUM_FULL = HUM_W'(10000);
   localparam logic [RAW_W-1:0] RAW_FULL = {RAW_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] CSR_DRY    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WET    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_EN = 2'd2;

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_CONV = 2'd1,
      REQ_READ = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_SAMPLING = 2'd1,
      PH_COMPLETE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STAT_HANDLED = 2'd0,
      STAT_READ_OK = 2'd1,
      STAT_NO_DATA = 2'd2,
      STAT_IGNORED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      SEQ_IDLE = 3'd0,
      SEQ_AVG  = 3'd1,
      SEQ_MAP  = 3'd2,
      SEQ_HUM  = 3'd3,
      SEQ_DONE = 3'd4
   } seq_state_type;

endpackage

`default_nettype wire

### rtl/smas_req_if.sv
`default_nettype none

interface smas_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  req_type;
   logic                        start_ok;
   logic                        conv_ok;
   logic [smas_pkg::RAW_W-1:0]  sample_value;

   modport source (output valid, output req_type, output start_ok, output conv_ok,
                   output sample_value, input ready);
   modport sink   (input valid, input req_type, input start_ok, input conv_ok,
                   input sample_value, output ready);
endinterface

`default_nettype wire

### rtl/smas_rsp_if.sv
`default_nettype none

interface smas_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic [smas_pkg::HUM_W-1:0]    humidity_out;
   logic                          data_ready;
   logic [1:0]                    phase;
   logic [smas_pkg::RAW_W-1:0]    average_raw;
   logic [smas_pkg::RETRY_W-1:0]  retry_level;

   modport source (output valid, output status, output humidity_out, output data_ready,
                   output phase, output average_raw, output retry_level, input ready);
   modport sink   (input valid, input status, input humidity_out, input data_ready,
                   input phase, input average_raw, input retry_level, output ready);
endinterface

`default_nettype wire

### rtl/soil_moisture_adc_sampler_top.sv
// channel    | direction | handshake           | payload
// req_chan   | in        | valid/ready         | req_type, start_ok, conv_ok, sample_value
// rsp_chan   | out       | valid/ready         | status, humidity_out, data_ready, phase,
//            |           |                     | average_raw, retry_level
// csr_*      | in        | csr_wr_en, no wait  | csr_index, csr_wdata
//
// ticks, reads and all but the last conversion of a run are handled in idle
// the last conversion runs two 14-step passes of the shared restoring
// divider (average, then humidity) plus a map and a finish state;
// the humidity pass is skipped when the calibrated clamp settles humidity
// one item at a time; req ready only in idle with the output register free
// a stalled rsp holds the output register; synchronous reset, active high

`default_nettype none

module soil_moisture_adc_sampler_top #(
   parameter int SAMPLES     = smas_pkg::SAMPLES_DEF,
   parameter int MAX_RETRIES = smas_pkg::MAX_RETRIES_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   smas_req_if.sink                         req_chan,
   smas_rsp_if.source                       rsp_chan,
   input  wire                              csr_wr_en,
   input  wire [smas_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [smas_pkg::RAW_W-1:0]        csr_wdata
);

   localparam int RAW_W   = smas_pkg::RAW_W;
   localparam int HUM_W   = smas_pkg::HUM_W;
   localparam int RETRY_W = smas_pkg::RETRY_W;
   localparam int QUO_W   = smas_pkg::QUO_W;
   localparam int NUM_W   = smas_pkg::NUM_W;
   localparam int STEP_W  = smas_pkg::STEP_W;
   localparam int SUM_W   = $clog2(SAMPLES * (2**RAW_W - 1) + 1);
   localparam int CNT_W   = $clog2(SAMPLES + 1);

   // sequencer and block state
   smas_pkg::seq_state_type state_ff, state_in;
   smas_pkg::phase_type     phase_ff, phase_in;
   logic [RETRY_W-1:0]      fail_ff, fail_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [CNT_W-1:0]        taken_ff, taken_in;
   logic [RAW_W-1:0]        avg_ff, avg_in;
   logic [HUM_W-1:0]        hum_ff, hum_in;
   logic                    pend_ff, pend_in;

   // shared divider
   logic [RAW_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [RAW_W-1:0]        den_ff, den_in;
   logic [STEP_W-1:0]       step_ff, step_in;

   // configuration
   logic [RAW_W-1:0]        dry_ff;
   logic [RAW_W-1:0]        wet_ff;
   logic                    cal_ff;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   smas_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [HUM_W-1:0]        rsp_hum_ff, rsp_hum_in;
   logic                    rsp_dready_ff, rsp_dready_in;
   smas_pkg::phase_type     rsp_phase_ff, rsp_phase_in;
   logic [RAW_W-1:0]        rsp_avg_ff, rsp_avg_in;
   logic [RETRY_W-1:0]      rsp_retry_ff, rsp_retry_in;

   logic                    accept;
   logic                    out_free;
   logic                    last_sample;
   logic [SUM_W-1:0]        sum_add;
   logic [CNT_W-1:0]        taken_inc;
   logic [RETRY_W-1:0]      fail_inc;
   logic                    fail_hit;
   logic [NUM_W-1:0]        num_avg;
   logic [RAW_W:0]          trial;
   logic [RAW_W:0]          trial_diff;
   logic                    trial_ge;
   logic [QUO_W-1:0]        quo_next;
   logic [RAW_W-1:0]        rem_next;
   logic                    div_last;
   logic                    above_dry;
   logic                    below_wet;
   logic                    clamp;
   logic [RAW_W-1:0]        map_diff;
   logic [RAW_W-1:0]        map_den;
   logic [NUM_W-1:0]        prod;
   logic                    rsp_load;
   smas_pkg::status_type    item_status;
   logic [HUM_W-1:0]        item_hum;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == smas_pkg::SEQ_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign sum_add     = sum_ff + SUM_W'(req_chan.sample_value);
   assign taken_inc   = taken_ff + 1'b1;
   assign last_sample = taken_inc >= CNT_W'(SAMPLES);
   assign fail_inc    = fail_ff + 1'b1;
   assign fail_hit    = fail_inc >= RETRY_W'(MAX_RETRIES);
   assign num_avg     = NUM_W'(sum_add);

   // one restoring step
   assign trial      = {rem_ff, quo_ff[QUO_W-1]};
   assign trial_ge   = trial >= {1'b0, den_ff};
   assign trial_diff = trial - {1'b0, den_ff};
   assign rem_next   = trial_ge ? trial_diff[RAW_W-1:0] : trial[RAW_W-1:0];
   assign quo_next   = {quo_ff[QUO_W-2:0], trial_ge};
   assign div_last   = step_ff == STEP_W'(QUO_W - 1);

   // humidity mapping operands
   assign above_dry = avg_ff >= dry_ff;
   assign below_wet = avg_ff <= wet_ff;
   assign clamp     = cal_ff && (above_dry || below_wet);
   assign map_diff  = cal_ff ? (dry_ff - avg_ff) : avg_ff;
   assign map_den   = cal_ff ? (dry_ff - wet_ff) : smas_pkg::RAW_FULL;
   assign prod      = NUM_W'(map_diff) * NUM_W'(smas_pkg::HUM_FULL);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smas_pkg::SEQ_IDLE: begin
            if (accept && req_chan.req_type == smas_pkg::REQ_CONV &&
                phase_ff == smas_pkg::PH_SAMPLING && req_chan.conv_ok && last_sample) begin
               state_in = smas_pkg::SEQ_AVG;
            end
         end
         smas_pkg::SEQ_AVG: begin
            if (div_last) begin
               state_in = smas_pkg::SEQ_MAP;
            end
         end
         smas_pkg::SEQ_MAP: begin
            if (clamp) begin
               state_in = smas_pkg::SEQ_DONE;
            end else begin
               state_in = smas_pkg::SEQ_HUM;
            end
         end
         smas_pkg::SEQ_HUM: begin
            if (div_last) begin
               state_in = smas_pkg::SEQ_DONE;
            end
         end
         smas_pkg::SEQ_DONE: begin
            if (out_free) begin
               state_in = smas_pkg::SEQ_IDLE;
            end
         end
         default: state_in = smas_pkg::SEQ_IDLE;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      fail_in       = fail_ff;
      sum_in        = sum_ff;
      taken_in      = taken_ff;
      avg_in        = avg_ff;
      hum_in        = hum_ff;
      pend_in       = pend_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      den_in        = den_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_hum_in    = rsp_hum_ff;
      rsp_dready_in = rsp_dready_ff;
      rsp_phase_in  = rsp_phase_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_retry_in  = rsp_retry_ff;
      rsp_load      = 1'b0;
      item_status   = smas_pkg::STAT_IGNORED;
      item_hum      = '0;
      case (state_ff)
         smas_pkg::SEQ_IDLE: begin
            if (accept) begin
               rsp_load = 1'b1;
               case (req_chan.req_type)
                  smas_pkg::REQ_TICK: begin
                     if (phase_ff == smas_pkg::PH_IDLE) begin
                        item_status = smas_pkg::STAT_HANDLED;
                        if (req_chan.start_ok) begin
                           phase_in = smas_pkg::PH_SAMPLING;
                           fail_in  = '0;
                           sum_in   = '0;
                           taken_in = '0;
                        end else if (fail_hit) begin
                           fail_in  = '0;
                           phase_in = smas_pkg::PH_IDLE;
                           pend_in  = 1'b0;
                        end else begin
                           fail_in = fail_inc;
                        end
                     end else if (phase_ff == smas_pkg::PH_COMPLETE) begin
                        item_status = smas_pkg::STAT_HANDLED;
                        if (!pend_ff) begin
                           phase_in = smas_pkg::PH_IDLE;
                        end
                     end
                  end
                  smas_pkg::REQ_CONV: begin
                     if (phase_ff == smas_pkg::PH_SAMPLING) begin
                        item_status = smas_pkg::STAT_HANDLED;
                        if (req_chan.conv_ok) begin
                           if (last_sample) begin
                              rsp_load = 1'b0;
                              rem_in   = num_avg[NUM_W-1:QUO_W];
                              quo_in   = num_avg[QUO_W-1:0];
                              den_in   = RAW_W'(SAMPLES);
                              step_in  = '0;
                              sum_in   = '0;
                              taken_in = '0;
                           end else begin
                              sum_in   = sum_add;
                              taken_in = taken_inc;
                           end
                        end else begin
                           sum_in   = '0;
                           taken_in = '0;
                           phase_in = smas_pkg::PH_IDLE;
                           if (fail_hit) begin
                              fail_in = '0;
                              pend_in = 1'b0;
                           end else begin
                              fail_in = fail_inc;
                           end
                        end
                     end
                  end
                  smas_pkg::REQ_READ: begin
                     if (pend_ff) begin
                        item_status = smas_pkg::STAT_READ_OK;
                        item_hum    = hum_ff;
                        pend_in     = 1'b0;
                     end else begin
                        item_status = smas_pkg::STAT_NO_DATA;
                     end
                  end
                  default: ;
               endcase
               if (rsp_load) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = item_status;
                  rsp_hum_in    = item_hum;
                  rsp_dready_in = pend_in;
                  rsp_phase_in  = phase_in;
                  rsp_avg_in    = avg_ff;
                  rsp_retry_in  = fail_in;
               end
            end
         end
         smas_pkg::SEQ_AVG: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (div_last) begin
               avg_in = quo_next[RAW_W-1:0];
            end
         end
         smas_pkg::SEQ_MAP: begin
            if (cal_ff && above_dry) begin
               hum_in = '0;
            end else if (cal_ff && below_wet) begin
               hum_in = smas_pkg::HUM_FULL;
            end else begin
               rem_in  = prod[NUM_W-1:QUO_W];
               quo_in  = prod[QUO_W-1:0];
               den_in  = map_den;
               step_in = '0;
            end
         end
         smas_pkg::SEQ_HUM: begin
            rem_in  = rem_next;
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (div_last) begin
               hum_in = quo_next;
            end
         end
         smas_pkg::SEQ_DONE: begin
            if (out_free) begin
               pend_in       = 1'b1;
               phase_in      = smas_pkg::PH_COMPLETE;
               fail_in       = '0;
               rsp_valid_in  = 1'b1;
               rsp_status_in = smas_pkg::STAT_HANDLED;
               rsp_hum_in    = '0;
               rsp_dready_in = 1'b1;
               rsp_phase_in  = smas_pkg::PH_COMPLETE;
               rsp_avg_in    = avg_ff;
               rsp_retry_in  = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smas_pkg::SEQ_IDLE;
         phase_ff     <= smas_pkg::PH_IDLE;
         fail_ff      <= '0;
         sum_ff       <= '0;
         taken_ff     <= '0;
         avg_ff       <= '0;
         hum_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         fail_ff      <= fail_in;
         sum_ff       <= sum_in;
         taken_ff     <= taken_in;
         avg_ff       <= avg_in;
         hum_ff       <= hum_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      den_ff        <= den_in;
      step_ff       <= step_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hum_ff    <= rsp_hum_in;
      rsp_dready_ff <= rsp_dready_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_retry_ff  <= rsp_retry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dry_ff <= '0;
         wet_ff <= '0;
         cal_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            smas_pkg::CSR_DRY:    dry_ff <= csr_wdata;
            smas_pkg::CSR_WET:    wet_ff <= csr_wdata;
            smas_pkg::CSR_CAL_EN: cal_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.humidity_out = rsp_hum_ff;
   assign rsp_chan.data_ready   = rsp_dready_ff;
   assign rsp_chan.phase        = rsp_phase_ff;
   assign rsp_chan.average_raw  = rsp_avg_ff;
   assign rsp_chan.retry_level  = rsp_retry_ff;

endmodule

`default_nettype wire

### rtl/smas_checker.sv
`default_nettype none

module smas_checker #(
   parameter int MAX_RETRIES = smas_pkg::MAX_RETRIES_DEF
) (
   input wire                             clock,
   input wire                             reset,
   input wire                             rsp_valid,
   input wire                             rsp_ready,
   input wire [1:0]                       status,
   input wire [smas_pkg::HUM_W-1:0]       humidity_out,
   input wire                             data_ready,
   input wire [1:0]                       phase,
   input wire [smas_pkg::RETRY_W-1:0]     retry_level
);

   // stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(humidity_out))
      else $error("rsp item changed while stalled");

   a_held_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && data_ready |-> phase == smas_pkg::PH_COMPLETE)
      else $error("data held outside complete phase");

   a_hum_only_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && humidity_out != '0 |-> status == smas_pkg::STAT_READ_OK)
      else $error("humidity shown without a delivered read");

   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == smas_pkg::STAT_READ_OK |-> !data_ready)
      else $error("data still held after delivered read");

   a_retry_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> retry_level < smas_pkg::RETRY_W'(MAX_RETRIES))
      else $error("retry count reached limit");

endmodule

bind soil_moisture_adc_sampler_top smas_checker #(.MAX_RETRIES(MAX_RETRIES)) u_smas_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .status       (rsp_chan.status),
   .humidity_out (rsp_chan.humidity_out),
   .data_ready   (rsp_chan.data_ready),
   .phase        (rsp_chan.phase),
   .retry_level  (rsp_chan.retry_level)
);

`default_nettype wire
